@@ hdl/http_chunked_body_decoder_assert.svh @@
// assertion macros for the chunked body decoder
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HCBD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbd same-cycle check failed");
// next-cycle implication
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbd next-cycle check failed");
`else
`define HCBD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/hcbd_pkg.sv @@
// types, codes and constants shared by the chunked body decoder
// no dependencies
`default_nettype none
package hcbd_pkg;

   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_BODY_LIMIT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHUNK_LIMIT = 1'd1;

   localparam logic [31:0] DEF_BODY_LIMIT    = 32'd10485760;
   localparam logic [31:0] CHUNK_LIMIT_RESET = 32'd1048576;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   // accumulator saturation value, 2^32
   localparam logic [32:0] ACCUM_CAP = 33'h1_0000_0000;

   typedef enum logic [3:0] {
      PH_SIZE    = 4'b0001,
      PH_DATA    = 4'b0010,
      PH_SKIP    = 4'b0100,
      PH_TRAILER = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      HS_LEAD   = 3'b001,
      HS_DIGITS = 3'b010,
      HS_DONE   = 3'b100
   } hex_stage_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_CHUNK = 2'd1,
      ERR_BODY  = 2'd2
   } err_type;

   typedef struct packed {
      phase_type     phase;
      logic [32:0]   size_accum;
      hex_stage_type hex_stage;
      logic          after_semicolon;
      logic          previous_was_cr;
      logic          line_is_empty;
      logic [31:0]   bytes_left;
      logic [1:0]    skip_count;
      logic [31:0]   payload_total;
      logic          done_flag;
      err_type       error_reg;
   } hcbd_state_type;

   localparam hcbd_state_type STATE_RESET = '{
      phase:           PH_SIZE,
      size_accum:      33'd0,
      hex_stage:       HS_LEAD,
      after_semicolon: 1'b0,
      previous_was_cr: 1'b0,
      line_is_empty:   1'b1,
      bytes_left:      32'd0,
      skip_count:      2'd0,
      payload_total:   32'd0,
      done_flag:       1'b0,
      error_reg:       ERR_NONE
   };

   typedef struct packed {
      logic [31:0] body_max;
      logic [31:0] chunk_limit;
   } hcbd_limits_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        complete;
      logic [1:0]  error_code;
      logic [31:0] body_length;
   } hcbd_result_type;

endpackage
`default_nettype wire

@@ hdl/hcbd_req_if.sv @@
// input byte channel of the chunked body decoder
// no dependencies
`default_nettype none
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink (input valid, input data_byte, input restart, output ready);
endinterface
`default_nettype wire

@@ hdl/hcbd_rsp_if.sv @@
// result channel of the chunked body decoder
// no dependencies
`default_nettype none
interface hcbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        complete;
   logic [1:0]  error_code;
   logic [31:0] body_length;

   modport source (output valid, output payload_byte, output payload_valid,
                   output complete, output error_code, output body_length, input ready);
   modport sink (input valid, input payload_byte, input payload_valid,
                 input complete, input error_code, input body_length, output ready);
endinterface
`default_nettype wire

@@ hdl/hcbd_csr_if.sv @@
// register write channel of the chunked body decoder
// depends on hcbd_pkg
`default_nettype none
interface hcbd_csr_if;
   import hcbd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [31:0]            wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

@@ hdl/hcbd_csr.sv @@
// limit registers of the chunked body decoder
// depends on hcbd_pkg and hcbd_csr_if
`default_nettype none
module hcbd_csr #(
   parameter logic [31:0] DEFAULT_BODY_LIMIT = hcbd_pkg::DEF_BODY_LIMIT
) (
   input  wire                      clock,
   input  wire                      reset,
   hcbd_csr_if.sink                 csr_chan,
   output hcbd_pkg::hcbd_limits_type limits
);
   import hcbd_pkg::*;

   logic [31:0] body_limit_ff;
   logic [31:0] chunk_limit_ff;
   logic [31:0] body_limit_in;
   logic [31:0] chunk_limit_in;
   logic        wr_beat;

   assign csr_chan.ready = 1'b1;
   assign wr_beat = csr_chan.valid;

   always_comb begin
      body_limit_in  = body_limit_ff;
      chunk_limit_in = chunk_limit_ff;
      if (wr_beat) begin
         case (csr_chan.reg_index)
            REG_BODY_LIMIT:  body_limit_in  = csr_chan.wr_data;
            REG_CHUNK_LIMIT: chunk_limit_in = csr_chan.wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_limit_ff  <= 32'd0;
         chunk_limit_ff <= CHUNK_LIMIT_RESET;
      end else begin
         body_limit_ff  <= body_limit_in;
         chunk_limit_ff <= chunk_limit_in;
      end
   end

   // zero body limit selects the built-in default
   assign limits.body_max    = (body_limit_ff != 32'd0) ? body_limit_ff : DEFAULT_BODY_LIMIT;
   assign limits.chunk_limit = chunk_limit_ff;
endmodule
`default_nettype wire

@@ hdl/hcbd_step.sv @@
// next-state and result logic for one body byte
// depends on hcbd_pkg
`default_nettype none
module hcbd_step (
   input  hcbd_pkg::hcbd_state_type  cur_state,
   input  wire [7:0]                 data_byte,
   input  wire                       restart,
   input  hcbd_pkg::hcbd_limits_type limits,
   output hcbd_pkg::hcbd_state_type  next_state,
   output hcbd_pkg::hcbd_result_type result
);
   import hcbd_pkg::*;

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // {digit valid, digit value}
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9")      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
      else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic hcbd_state_type size_content(hcbd_state_type s, logic [7:0] c);
      hcbd_state_type r;
      logic [4:0]     hd;
      logic [36:0]    v;
      r  = s;
      hd = hex_digit(c);
      v  = {s.size_accum, hd[3:0]};
      if (!s.after_semicolon) begin
         if (c == CHAR_SEMI) begin
            r.after_semicolon = 1'b1;
         end else begin
            case (s.hex_stage)
               HS_LEAD: begin
                  if (hd[4]) begin
                     r.hex_stage  = HS_DIGITS;
                     r.size_accum = {29'd0, hd[3:0]};
                  end else if (!is_space(c)) begin
                     r.hex_stage = HS_DONE;
                  end
               end
               HS_DIGITS: begin
                  if (hd[4]) begin
                     r.size_accum = (v > {4'd0, ACCUM_CAP}) ? ACCUM_CAP : v[32:0];
                  end else begin
                     r.hex_stage = HS_DONE;
                  end
               end
               default: ;
            endcase
         end
      end
      return r;
   endfunction

   function automatic hcbd_state_type line_content(hcbd_state_type s, logic [7:0] c);
      hcbd_state_type r;
      r = s;
      if (s.phase == PH_SIZE) r = size_content(s, c);
      else r.line_is_empty = 1'b0;
      return r;
   endfunction

   function automatic hcbd_state_type line_end(hcbd_state_type s, hcbd_limits_type lim);
      hcbd_state_type r;
      logic [33:0]    total;
      r     = s;
      total = {2'd0, s.payload_total} + {1'b0, s.size_accum};
      if (s.phase == PH_TRAILER) begin
         if (s.line_is_empty) r.done_flag = 1'b1;
         r.line_is_empty = 1'b1;
      end else begin
         r.size_accum      = 33'd0;
         r.hex_stage       = HS_LEAD;
         r.after_semicolon = 1'b0;
         r.line_is_empty   = 1'b1;
         if (s.size_accum > {1'b0, lim.chunk_limit}) begin
            r.done_flag = 1'b1;
            r.error_reg = ERR_CHUNK;
         end else if (total > {2'd0, lim.body_max}) begin
            r.done_flag = 1'b1;
            r.error_reg = ERR_BODY;
         end else if (s.size_accum == 33'd0) begin
            r.phase = PH_TRAILER;
         end else begin
            r.bytes_left = s.size_accum[31:0];
            r.phase      = PH_DATA;
         end
      end
      return r;
   endfunction

   hcbd_state_type base;
   hcbd_state_type line_st;
   hcbd_state_type nxt;
   logic [1:0]     skip_dec;
   logic           pay;

   always_comb begin
      base     = restart ? STATE_RESET : cur_state;
      nxt      = base;
      line_st  = base;
      pay      = 1'b0;
      skip_dec = (base.skip_count != 2'd0) ? base.skip_count - 2'd1 : 2'd0;
      if (!base.done_flag) begin
         case (base.phase)
            PH_DATA: begin
               pay               = 1'b1;
               nxt.payload_total = base.payload_total + 32'd1;
               nxt.bytes_left    = base.bytes_left - 32'd1;
               if (base.bytes_left == 32'd1) begin
                  nxt.phase      = PH_SKIP;
                  nxt.skip_count = 2'd2;
               end
            end
            PH_SKIP: begin
               nxt.skip_count = skip_dec;
               if (skip_dec == 2'd0) begin
                  nxt.phase           = PH_SIZE;
                  nxt.previous_was_cr = 1'b0;
               end
            end
            PH_SIZE, PH_TRAILER: begin
               // a held cr either closes the line or counts as a content byte
               if (base.previous_was_cr) begin
                  line_st.previous_was_cr = 1'b0;
                  if (data_byte != CHAR_LF) line_st = line_content(line_st, CHAR_CR);
               end
               if (base.previous_was_cr && data_byte == CHAR_LF) begin
                  nxt = line_end(line_st, limits);
               end else if (data_byte == CHAR_CR) begin
                  nxt = line_st;
                  nxt.previous_was_cr = 1'b1;
               end else begin
                  nxt = line_content(line_st, data_byte);
               end
            end
            default: ;
         endcase
      end
   end

   assign next_state           = nxt;
   assign result.payload_byte  = pay ? data_byte : 8'd0;
   assign result.payload_valid = pay;
   assign result.complete      = nxt.done_flag;
   assign result.error_code    = nxt.error_reg;
   assign result.body_length   = nxt.payload_total;
endmodule
`default_nettype wire

@@ hdl/http_chunked_body_decoder.sv @@
// an accepted byte is held in the input stage register, then its result beat in the result register
// throughput: one byte per cycle while result beats are taken; the decoder state register updates once per byte
// a full result register does not block input at once: one byte can wait in the input stage
// reset is synchronous: it clears the decoder state, both stages and the limit registers
// (body limit 0, chunk limit 1048576); no clearing pass is needed
// depends on hcbd_pkg, the channel interfaces, hcbd_csr and hcbd_step
`default_nettype none
`include "http_chunked_body_decoder_assert.svh"
module http_chunked_body_decoder #(
   parameter logic [31:0] DEFAULT_BODY_LIMIT = hcbd_pkg::DEF_BODY_LIMIT
) (
   input  wire        clock,
   input  wire        reset,
   hcbd_req_if.sink   req_chan,
   hcbd_rsp_if.source rsp_chan,
   hcbd_csr_if.sink   csr_chan
);
   import hcbd_pkg::*;

   // input stage
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_restart_ff;

   // result register
   logic            out_valid_ff;
   logic            out_valid_in;
   hcbd_result_type out_res_ff;

   // decoder state, updated as a byte moves into the result register
   hcbd_state_type  st_ff;
   hcbd_state_type  st_in;

   hcbd_state_type  step_state;
   hcbd_result_type step_res;
   hcbd_limits_type limits;

   logic            out_free;
   logic            s1_move;
   logic            req_beat;

   hcbd_csr #(
      .DEFAULT_BODY_LIMIT (DEFAULT_BODY_LIMIT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .limits   (limits)
   );

   hcbd_step u_step (
      .cur_state  (st_ff),
      .data_byte  (s1_byte_ff),
      .restart    (s1_restart_ff),
      .limits     (limits),
      .next_state (step_state),
      .result     (step_res)
   );

   // result register frees up when empty or when its beat is taken
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   // input stage takes a new byte when empty or when its byte moves on
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_beat       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = req_beat ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      st_in        = s1_move ? step_state : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         st_ff        <= st_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_byte_ff    <= req_chan.data_byte;
         s1_restart_ff <= req_chan.restart;
      end
      if (s1_move) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.payload_byte  = out_res_ff.payload_byte;
   assign rsp_chan.payload_valid = out_res_ff.payload_valid;
   assign rsp_chan.complete      = out_res_ff.complete;
   assign rsp_chan.error_code    = out_res_ff.error_code;
   assign rsp_chan.body_length   = out_res_ff.body_length;

   // a stop code is only ever set together with the done flag
   `HCBD_ASSERT_IMPLIES(a_err_done, clock, reset, st_ff.error_reg != ERR_NONE, st_ff.done_flag)
   // payload phase never sits with nothing left to pass
   `HCBD_ASSERT_IMPLIES(a_data_left, clock, reset, st_ff.phase == PH_DATA, st_ff.bytes_left != 32'd0)
   // a finished body stays finished until a restart byte goes through
   `HCBD_ASSERT_NEXT(a_done_holds, clock, reset, st_ff.done_flag && !(s1_move && s1_restart_ff), st_ff.done_flag)
   // input backpressure only while the input stage holds a byte
   `HCBD_ASSERT_IMPLIES(a_ready_low, clock, reset, !req_chan.ready, s1_valid_ff && out_valid_ff)
endmodule
`default_nettype wire
